// ===== hw/rtl/screen_triangle_pick_nearest_macros.svh =====
// Assertion macros shared by the pick block RTL.
`ifndef SCREEN_TRIANGLE_PICK_NEAREST_MACROS_SVH
`define SCREEN_TRIANGLE_PICK_NEAREST_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define STPN_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its cause.
`define STPN_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/stpn_pkg.sv =====
// Types and constants shared by the pick block modules.
`default_nettype none

package stpn_pkg;

   localparam int COORD_BITS      = 16;
   localparam int DEPTH_BITS      = 24;
   localparam int SUM_BITS        = DEPTH_BITS + 2;
   localparam int DIFF_BITS       = COORD_BITS + 1;
   localparam int PROD_BITS       = 2 * DIFF_BITS;
   localparam int EDGE_BITS       = PROD_BITS + 1;
   localparam int EDGE_COUNT      = 4;
   localparam int DEPTH_TERMS     = 3;
   localparam int STPN_QUEUE_DEPTH = 8;

   // Magnitude of a depth sum and its reciprocal-of-three scaling.
   localparam int MAG_BITS     = SUM_BITS;
   localparam int RECIP_SHIFT  = MAG_BITS + 2;
   localparam int RECIP_BITS   = MAG_BITS + 1;
   localparam int SCALED_BITS  = MAG_BITS + RECIP_BITS;
   localparam logic [RECIP_BITS-1:0] RECIP_THIRD =
      RECIP_BITS'((64'd1 << RECIP_SHIFT) / 64'd3);

   localparam logic signed [SUM_BITS-1:0] BEST_SUM_RESET = {1'b0, {(SUM_BITS-1){1'b1}}};

   localparam int CSR_INDEX_BITS = 1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PICK_X = 1'b0,
      CSR_PICK_Y = 1'b1
   } stpn_csr_index_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] vertex_a_x;
      logic signed [COORD_BITS-1:0] vertex_a_y;
      logic signed [COORD_BITS-1:0] vertex_b_x;
      logic signed [COORD_BITS-1:0] vertex_b_y;
      logic signed [COORD_BITS-1:0] vertex_c_x;
      logic signed [COORD_BITS-1:0] vertex_c_y;
      logic signed [DEPTH_BITS-1:0] depth_a;
      logic signed [DEPTH_BITS-1:0] depth_b;
      logic signed [DEPTH_BITS-1:0] depth_c;
      logic                         last_triangle;
   } stpn_req_type;

   typedef struct packed {
      logic                         pick_hit;
      logic signed [DEPTH_BITS-1:0] nearest_depth;
   } stpn_rsp_type;

   // One classified triangle, passed from the front to the back.
   typedef struct packed {
      logic                       covered;
      logic                       last;
      logic signed [SUM_BITS-1:0] depth_sum;
   } stpn_entry_type;

endpackage

`default_nettype wire

// ===== hw/rtl/stpn_front.sv =====
// Front end: accept triangles, run the edge tests, classify hits.
`default_nettype none
`include "screen_triangle_pick_nearest_macros.svh"

module stpn_front import stpn_pkg::*; #(
   parameter int QUEUE_DEPTH = STPN_QUEUE_DEPTH,
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire stpn_req_type                 req_data,
   input  wire logic signed [COORD_BITS-1:0] pick_x,
   input  wire logic signed [COORD_BITS-1:0] pick_y,
   input  wire logic [COUNT_BITS-1:0]        queue_count,
   output logic                              push_valid,
   output stpn_entry_type                    push_entry
);

   logic signed [DIFF_BITS-1:0] ax, ay, bx, by, cx, cy, px, py;
   logic signed [DIFF_BITS-1:0] op_in  [EDGE_COUNT][4];
   logic signed [DIFF_BITS-1:0] op_ff  [EDGE_COUNT][4];
   logic signed [PROD_BITS-1:0] prod_in [EDGE_COUNT][2];
   logic signed [PROD_BITS-1:0] prod_ff [EDGE_COUNT][2];
   logic signed [EDGE_BITS-1:0] edge_in [EDGE_COUNT];
   logic signed [EDGE_BITS-1:0] edge_ff [EDGE_COUNT];
   logic signed [SUM_BITS-1:0]  sum_in, s1_sum_ff, s2_sum_ff, s3_sum_ff;
   logic                        s1_last_ff, s2_last_ff, s3_last_ff;
   logic                        s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [COUNT_BITS:0]         in_flight_total;
   logic                        accept;
   logic                        area_neg, area_zero, all_le, all_ge;

   // Reserve queue room for everything still in the edge pipeline.
   assign in_flight_total = (COUNT_BITS+1)'(queue_count) + (COUNT_BITS+1)'(s1_valid_ff)
                          + (COUNT_BITS+1)'(s2_valid_ff) + (COUNT_BITS+1)'(s3_valid_ff);
   assign req_stall = reset || (in_flight_total >= (COUNT_BITS+1)'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;

   always_comb begin
      ax = DIFF_BITS'(req_data.vertex_a_x);
      ay = DIFF_BITS'(req_data.vertex_a_y);
      bx = DIFF_BITS'(req_data.vertex_b_x);
      by = DIFF_BITS'(req_data.vertex_b_y);
      cx = DIFF_BITS'(req_data.vertex_c_x);
      cy = DIFF_BITS'(req_data.vertex_c_y);
      px = DIFF_BITS'(pick_x);
      py = DIFF_BITS'(pick_y);
      // edge = op0 * op1 - op2 * op3; first row is the doubled area
      op_in[0] = '{cx - ax, by - ay, cy - ay, bx - ax};
      op_in[1] = '{px - bx, cy - by, py - by, cx - bx};
      op_in[2] = '{px - cx, ay - cy, py - cy, ax - cx};
      op_in[3] = '{px - ax, by - ay, py - ay, bx - ax};
      sum_in = SUM_BITS'(req_data.depth_a) + SUM_BITS'(req_data.depth_b)
             + SUM_BITS'(req_data.depth_c);
   end

   always_comb begin
      for (int k = 0; k < EDGE_COUNT; k++) begin
         prod_in[k][0] = PROD_BITS'(op_ff[k][0]) * PROD_BITS'(op_ff[k][1]);
         prod_in[k][1] = PROD_BITS'(op_ff[k][2]) * PROD_BITS'(op_ff[k][3]);
         edge_in[k]    = EDGE_BITS'(prod_ff[k][0]) - EDGE_BITS'(prod_ff[k][1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= op_in;
         s1_sum_ff  <= sum_in;
         s1_last_ff <= req_data.last_triangle;
      end
      prod_ff    <= prod_in;
      s2_sum_ff  <= s1_sum_ff;
      s2_last_ff <= s1_last_ff;
      edge_ff    <= edge_in;
      s3_sum_ff  <= s2_sum_ff;
      s3_last_ff <= s2_last_ff;
   end

   // Inclusive test against the sign of the area; zero area never hits.
   always_comb begin
      area_neg  = edge_ff[0] < 0;
      area_zero = edge_ff[0] == '0;
      all_le    = (edge_ff[1] <= 0) && (edge_ff[2] <= 0) && (edge_ff[3] <= 0);
      all_ge    = (edge_ff[1] >= 0) && (edge_ff[2] >= 0) && (edge_ff[3] >= 0);
      push_valid           = s3_valid_ff;
      push_entry.covered   = !area_zero && (area_neg ? all_le : all_ge);
      push_entry.last      = s3_last_ff;
      push_entry.depth_sum = s3_sum_ff;
   end

   `STPN_ASSERT_NOW(a_credit_bound, clock, reset, 1'b1,
      in_flight_total <= (COUNT_BITS+1)'(QUEUE_DEPTH), "front overcommitted the queue")

endmodule

`default_nettype wire

// ===== hw/rtl/stpn_queue.sv =====
// Queue of classified triangles between the front and the back.
`default_nettype none
`include "screen_triangle_pick_nearest_macros.svh"

module stpn_queue import stpn_pkg::*; #(
   parameter int QUEUE_DEPTH = STPN_QUEUE_DEPTH,
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1),
   localparam int PTR_BITS   = $clog2(QUEUE_DEPTH)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire stpn_entry_type        push_entry,
   input  wire logic                  pop,
   output logic                       head_valid,
   output stpn_entry_type             head_entry,
   output logic [COUNT_BITS-1:0]      count
);

   stpn_entry_type        storage_ff [QUEUE_DEPTH];
   stpn_entry_type        head_ff;
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + COUNT_BITS'(push) - COUNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Register the next head; take the incoming entry when it lands at the head.
   always_ff @(posedge clock) begin
      if (push) begin
         storage_ff[wr_ptr_ff] <= push_entry;
      end
      if (push && (wr_ptr_ff == rd_ptr_in)) begin
         head_ff <= push_entry;
      end else begin
         head_ff <= storage_ff[rd_ptr_in];
      end
   end

   assign head_valid = count_ff != '0;
   assign head_entry = head_ff;
   assign count      = count_ff;

   `STPN_ASSERT_NOW(a_no_overflow, clock, reset, push,
      count_ff < COUNT_BITS'(QUEUE_DEPTH), "push into a full queue")
   `STPN_ASSERT_NOW(a_no_underflow, clock, reset, pop,
      count_ff != '0, "pop from an empty queue")

endmodule

`default_nettype wire

// ===== hw/rtl/stpn_back.sv =====
// Back end: keep the nearest hit, divide its sum by three, hold the result.
`default_nettype none
`include "screen_triangle_pick_nearest_macros.svh"

module stpn_back import stpn_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           head_valid,
   input  wire stpn_entry_type head_entry,
   output logic                pop,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   output stpn_rsp_type        rsp_data
);

   logic signed [SUM_BITS-1:0] best_ff, best_in, best_next;
   logic                       hit_ff, hit_in, hit_next;
   logic                       r1_valid_ff, r1_valid_in, r1_hit_ff, r1_neg_ff;
   logic [MAG_BITS-1:0]        r1_mag_ff, mag_in;
   logic                       r2_valid_ff, r2_valid_in, r2_hit_ff, r2_neg_ff;
   logic [MAG_BITS-1:0]        r2_mag_ff, r2_q0_ff;
   logic [SCALED_BITS-1:0]     scaled;
   logic                       rsp_valid_ff, rsp_valid_in;
   stpn_rsp_type               rsp_data_ff, rsp_data_in;
   logic                       out_ready, r2_ready, r1_ready, take_last;
   logic [MAG_BITS+1:0]        three_q, rem;
   logic [MAG_BITS-1:0]        quot, quot_signed;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign r2_ready  = !r2_valid_ff || out_ready;
   assign r1_ready  = !r1_valid_ff || r2_ready;
   assign pop       = head_valid && (!head_entry.last || r1_ready);
   assign take_last = pop && head_entry.last;

   always_comb begin
      hit_next  = hit_ff || head_entry.covered;
      best_next = best_ff;
      if (head_entry.covered && (!hit_ff || (head_entry.depth_sum < best_ff))) begin
         best_next = head_entry.depth_sum;
      end
      best_in = best_ff;
      hit_in  = hit_ff;
      if (take_last) begin
         best_in = BEST_SUM_RESET;
         hit_in  = 1'b0;
      end else if (pop) begin
         best_in = best_next;
         hit_in  = hit_next;
      end
      mag_in = best_next[SUM_BITS-1] ? MAG_BITS'(-best_next) : MAG_BITS'(best_next);
   end

   // Quotient estimate is floor(m/3) or one below it; fix it up at the output.
   assign scaled = SCALED_BITS'(r1_mag_ff) * SCALED_BITS'(RECIP_THIRD);

   always_comb begin
      three_q     = ((MAG_BITS+2)'(r2_q0_ff) << 1) + (MAG_BITS+2)'(r2_q0_ff);
      rem         = (MAG_BITS+2)'(r2_mag_ff) - three_q;
      quot        = r2_q0_ff + MAG_BITS'(rem >= (MAG_BITS+2)'(DEPTH_TERMS));
      quot_signed = r2_neg_ff ? -quot : quot;
      rsp_data_in.pick_hit      = r2_hit_ff;
      rsp_data_in.nearest_depth = r2_hit_ff ? DEPTH_BITS'(quot_signed) : '0;
   end

   assign r1_valid_in  = (r1_valid_ff && !r2_ready) || take_last;
   assign r2_valid_in  = (r2_valid_ff && !out_ready) || (r1_valid_ff && r2_ready);
   assign rsp_valid_in = (rsp_valid_ff && !out_ready) || (r2_valid_ff && out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff      <= BEST_SUM_RESET;
         hit_ff       <= 1'b0;
         r1_valid_ff  <= 1'b0;
         r2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         best_ff      <= best_in;
         hit_ff       <= hit_in;
         r1_valid_ff  <= r1_valid_in;
         r2_valid_ff  <= r2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_last) begin
         r1_hit_ff <= hit_next;
         r1_neg_ff <= best_next[SUM_BITS-1];
         r1_mag_ff <= mag_in;
      end
      if (r1_valid_ff && r2_ready) begin
         r2_hit_ff <= r1_hit_ff;
         r2_neg_ff <= r1_neg_ff;
         r2_mag_ff <= r1_mag_ff;
         r2_q0_ff  <= MAG_BITS'(scaled >> RECIP_SHIFT);
      end
      if (r2_valid_ff && out_ready) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `STPN_ASSERT_NEXT(a_query_cleared, clock, reset, take_last,
      !hit_ff && (best_ff == BEST_SUM_RESET), "query state not cleared after last triangle")

endmodule

`default_nettype wire

// ===== hw/rtl/screen_triangle_pick_nearest.sv =====
// Top level of the nearest-triangle pick block.
//
// Usage:
//   Program the pick point through the csr_ port (index 0 = pick_x,
//   index 1 = pick_y) while the block is idle. Stream screen triangles on
//   the req_ channel; a transfer happens when req_valid is high and
//   req_stall is low. Mark the final triangle of a query with
//   last_triangle. That triangle yields one transfer on the rsp_ channel
//   carrying pick_hit and the mean depth of the nearest hit (0 on a miss);
//   other triangles yield nothing.
// Throughput: one triangle per cycle while req_stall is low, set by the
//   fully pipelined edge multipliers in the front and the running
//   minimum in the back.
// Result path: a last triangle passes the edge stages s1, s2 and s3, the queue,
//   the divide stages r1 and r2 and the output register before rsp_valid.
// Reset: synchronous; clears the pick point to the origin, empties the
//   pipeline and queue, and starts a fresh query. req_stall is high during it.
// Stall: a stalled result holds in the output register; the back keeps
//   consuming non-final triangles, and the front keeps accepting until the
//   queue plus the edge pipeline would exceed the queue depth.

`default_nettype none

module screen_triangle_pick_nearest import stpn_pkg::*; #(
   parameter int QUEUE_DEPTH = STPN_QUEUE_DEPTH
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire stpn_req_type              req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output stpn_rsp_type                   rsp_data,
   input  wire logic                      csr_write,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [COORD_BITS-1:0]     csr_wdata
);

   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   logic signed [COORD_BITS-1:0] pick_x_ff, pick_x_in, pick_y_ff, pick_y_in;
   logic                         push_valid, pop, head_valid;
   stpn_entry_type               push_entry, head_entry;
   logic [COUNT_BITS-1:0]        queue_count;

   // Decode register writes; hold the other register.
   always_comb begin
      pick_x_in = pick_x_ff;
      pick_y_in = pick_y_ff;
      if (csr_write) begin
         unique case (stpn_csr_index_type'(csr_index))
            CSR_PICK_X: pick_x_in = csr_wdata;
            CSR_PICK_Y: pick_y_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pick_x_ff <= '0;
         pick_y_ff <= '0;
      end else begin
         pick_x_ff <= pick_x_in;
         pick_y_ff <= pick_y_in;
      end
   end

   // Front: edge tests, one triangle per cycle unless req_stall is high.
   stpn_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .pick_x      (pick_x_ff),
      .pick_y      (pick_y_ff),
      .queue_count (queue_count),
      .push_valid  (push_valid),
      .push_entry  (push_entry)
   );

   // Queue: decouple the classifier from the result path.
   stpn_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .count      (queue_count)
   );

   // Back: running minimum, divide by three, output register.
   stpn_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the nearest-triangle pick block.
module testbench import stpn_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_MAX      = 2 ** (COORD_BITS - 1) - 1;
   localparam int COORD_MIN      = -(2 ** (COORD_BITS - 1));
   localparam int DEPTH_MAX      = 2 ** (DEPTH_BITS - 1) - 1;
   localparam int DEPTH_MIN      = -(2 ** (DEPTH_BITS - 1));
   localparam int SETTLE_CYCLES  = 32;    // pipeline, queue and divider with margin
   localparam int HOLD_OFF_LEN   = 300;   // long output hold-off to back up the input
   localparam int REPORT_LIMIT   = 10;

   // DUT interface; every input starts at a known value.
   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_valid  = 1'b0;
   logic                      req_stall;
   stpn_req_type              req_data   = '0;
   logic                      rsp_valid;
   logic                      rsp_stall  = 1'b0;
   stpn_rsp_type              rsp_data;
   logic                      csr_write  = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index  = CSR_PICK_X;
   logic [COORD_BITS-1:0]     csr_wdata  = '0;

   // Triangles waiting to be offered, and pick results still owed by the block.
   stpn_req_type triangles_to_send[$];
   stpn_rsp_type due_picks[$];

   // Shadow of the block: pick point and the running nearest hit of the open query.
   logic signed [COORD_BITS-1:0] aim_x = '0;
   logic signed [COORD_BITS-1:0] aim_y = '0;
   logic signed [SUM_BITS-1:0]   nearest_sum = BEST_SUM_RESET;
   logic                         query_hit = 1'b0;

   // Traffic shaping.
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   bit hold_off           = 1'b0;
   bit pressure_requested = 1'b0;
   bit req_moved          = 1'b0;

   // Run statistics.
   int failures           = 0;
   int triangles_seen     = 0;
   int picks_checked      = 0;
   int picks_hit          = 0;
   int input_held_cycles  = 0;

   screen_triangle_pick_nearest dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Append one triangle to the pending list.
   function automatic void add_triangle(input stpn_req_type t);
      triangles_to_send.insert(triangles_to_send.size(), t);
   endfunction

   // Doubled signed area of (p, q, r); 35 bits hold it exactly.
   function automatic logic signed [EDGE_BITS-1:0] edge_value(
      input logic signed [COORD_BITS-1:0] px, py, qx, qy, rx, ry);
      return (EDGE_BITS'(rx) - EDGE_BITS'(px)) * (EDGE_BITS'(qy) - EDGE_BITS'(py))
           - (EDGE_BITS'(ry) - EDGE_BITS'(py)) * (EDGE_BITS'(qx) - EDGE_BITS'(px));
   endfunction

   // Classify one accepted triangle against the pick point, fold it into the
   // open query, and owe a result when it closes the query.
   function automatic void fold_triangle(input stpn_req_type t);
      logic signed [EDGE_BITS-1:0] area, w0, w1, w2;
      logic signed [SUM_BITS-1:0]  depth_sum, mean_depth;
      logic                        covered;
      stpn_rsp_type                pick;
      covered = 1'b0;
      area = edge_value(t.vertex_a_x, t.vertex_a_y, t.vertex_b_x, t.vertex_b_y,
                        t.vertex_c_x, t.vertex_c_y);
      // A degenerate triangle never covers anything.
      if (area != 0) begin
         w0 = edge_value(t.vertex_b_x, t.vertex_b_y, t.vertex_c_x, t.vertex_c_y, aim_x, aim_y);
         w1 = edge_value(t.vertex_c_x, t.vertex_c_y, t.vertex_a_x, t.vertex_a_y, aim_x, aim_y);
         w2 = edge_value(t.vertex_a_x, t.vertex_a_y, t.vertex_b_x, t.vertex_b_y, aim_x, aim_y);
         // Boundaries count; clockwise winding flips the required sign.
         if (area < 0) begin
            covered = (w0 <= 0) && (w1 <= 0) && (w2 <= 0);
         end else begin
            covered = (w0 >= 0) && (w1 >= 0) && (w2 >= 0);
         end
      end
      if (covered) begin
         depth_sum = SUM_BITS'(t.depth_a) + SUM_BITS'(t.depth_b) + SUM_BITS'(t.depth_c);
         // Only a strictly nearer triangle replaces the kept one.
         if (!query_hit || depth_sum < nearest_sum) begin
            nearest_sum = depth_sum;
         end
         query_hit = 1'b1;
      end
      if (t.last_triangle) begin
         mean_depth = SUM_BITS'(nearest_sum / DEPTH_TERMS);   // truncates toward zero
         pick.pick_hit      = query_hit;
         pick.nearest_depth = query_hit ? mean_depth[DEPTH_BITS-1:0] : '0;
         due_picks.insert(due_picks.size(), pick);
         nearest_sum = BEST_SUM_RESET;
         query_hit   = 1'b0;
      end
   endfunction

   function automatic void log_failure(input string detail);
      failures++;
      if (failures <= REPORT_LIMIT) begin
         $display("ERROR @%0t: %s", $realtime, detail);
      end
   endfunction

   function automatic logic signed [COORD_BITS-1:0] clamp_coord(input int v);
      if (v > COORD_MAX) return COORD_BITS'(COORD_MAX);
      if (v < COORD_MIN) return COORD_BITS'(COORD_MIN);
      return COORD_BITS'(v);
   endfunction

   function automatic stpn_req_type make_triangle(input int ax, ay, bx, by, cx, cy,
                                                  input int da, db, dc, input bit last);
      stpn_req_type t;
      t.vertex_a_x    = clamp_coord(ax);
      t.vertex_a_y    = clamp_coord(ay);
      t.vertex_b_x    = clamp_coord(bx);
      t.vertex_b_y    = clamp_coord(by);
      t.vertex_c_x    = clamp_coord(cx);
      t.vertex_c_y    = clamp_coord(cy);
      t.depth_a       = DEPTH_BITS'(da);
      t.depth_b       = DEPTH_BITS'(db);
      t.depth_c       = DEPTH_BITS'(dc);
      t.last_triangle = last;
      return t;
   endfunction

   function automatic int random_coord();
      return int'($signed(COORD_BITS'($urandom)));
   endfunction

   function automatic int near(input int centre, input int spread);
      return centre + int'($urandom_range(2 * spread)) - spread;
   endfunction

   function automatic int random_depth();
      case ($urandom_range(9))
         0:       return DEPTH_MIN;
         1:       return DEPTH_MAX;
         2, 3:    return int'($signed(DEPTH_BITS'($urandom)));
         default: return int'($urandom_range(1 << 18)) - (1 << 17);
      endcase
   endfunction

   // Queue one pick query of len triangles aimed around (px, py); the last
   // one closes the query.
   task automatic queue_query(input int px, input int py, input int len);
      int ax, ay, bx, by, cx, cy, dx, dy, k, spread;
      int da, db, dc;
      da = 0;
      db = 0;
      dc = 0;
      for (int n = 0; n < len; n++) begin
         case ($urandom_range(3))
            0:       spread = 2;
            1:       spread = 16;
            2:       spread = 1000;
            default: spread = 40000;
         endcase
         ax = near(px, spread);
         ay = near(py, spread);
         bx = near(px, spread);
         by = near(py, spread);
         cx = near(px, spread);
         cy = near(py, spread);
         case ($urandom_range(19))
            // Collinear or coincident vertices.
            0, 1, 2: begin
               dx = int'($urandom_range(2 * spread)) - spread;
               dy = int'($urandom_range(2 * spread)) - spread;
               k  = int'($urandom_range(6)) - 3;
               if ($urandom_range(3) == 0) begin
                  dx = 0;
                  dy = 0;
               end
               bx = ax + dx;
               by = ay + dy;
               cx = ax + k * dx;
               cy = ay + k * dy;
            end
            // Pick point on a vertex.
            3, 4: begin
               ax = px;
               ay = py;
            end
            // Pick point at the midpoint of edge a-b.
            5, 6: begin
               bx = 2 * px - ax;
               by = 2 * py - ay;
            end
            // Unrelated triangle anywhere on screen.
            7, 8, 9, 10: begin
               ax = random_coord();
               ay = random_coord();
               bx = random_coord();
               by = random_coord();
               cx = random_coord();
               cy = random_coord();
            end
            default: ;
         endcase
         // Reuse the previous depths now and then to force depth ties.
         if (n == 0 || $urandom_range(7) != 0) begin
            da = random_depth();
            db = random_depth();
            dc = random_depth();
         end
         add_triangle(make_triangle(ax, ay, bx, by, cx, cy, da, db, dc, n == len - 1));
      end
   endtask

   // Hold until every triangle is in, every result is out, and trailing
   // non-final triangles have left the pipeline.
   task automatic wait_idle();
      while (triangles_to_send.size() != 0 || req_valid) @(posedge clock);
      while (due_picks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_pick_point(input int x, input int y);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_PICK_X;
      csr_wdata <= COORD_BITS'(x);
      @(negedge clock);
      csr_index <= CSR_PICK_Y;
      csr_wdata <= COORD_BITS'(y);
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // One random phase: program the pick point, set the idling mix, stream
   // queries, and drain. Squeeze keeps queries short and holds the output off.
   task automatic run_phase(input int x, input int y, input int idle_pct,
                            input int stall_pct, input int count, input bit squeeze);
      int queued;
      int len;
      set_pick_point(x, y);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      queued = 0;
      while (queued < count) begin
         if (squeeze) begin
            len = $urandom_range(1, 2);
         end else if ($urandom_range(9) == 0) begin
            len = $urandom_range(8, 20);
         end else begin
            len = $urandom_range(1, 5);
         end
         queue_query(x, y, len);
         queued += len;
      end
      if (squeeze) begin
         pressure_requested = 1'b1;
      end
      wait_idle();
   endtask

   // Driver: advance to the next triangle only after a transfer or while idle.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_moved) begin
         if (triangles_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_data  <= triangles_to_send.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, forced high during the hold-off.
   always @(negedge clock) begin
      rsp_stall <= hold_off || ($urandom_range(99) < receiver_stall_pct);
   end

   // Hold-off: keep the result side stalled for a long fixed stretch so the
   // block backs up and stalls its input.
   initial begin
      while (!pressure_requested) @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_OFF_LEN) @(posedge clock);
      hold_off <= 1'b0;
   end

   // Monitor: track register writes, check results, and predict from each
   // accepted triangle. Results are checked before the same-edge transfer is
   // folded in; they can only stem from earlier triangles.
   always @(posedge clock) begin
      stpn_rsp_type want;
      req_moved = !reset && req_valid && !req_stall;
      if (reset) begin
         aim_x       = '0;
         aim_y       = '0;
         nearest_sum = BEST_SUM_RESET;
         query_hit   = 1'b0;
      end else begin
         if (csr_write) begin
            case (stpn_csr_index_type'(csr_index))
               CSR_PICK_X: aim_x = csr_wdata;
               CSR_PICK_Y: aim_y = csr_wdata;
               default: ;
            endcase
         end
         if (hold_off && req_valid && req_stall) begin
            input_held_cycles++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_picks.size() == 0) begin
               log_failure($sformatf("unexpected pick result: hit=%0d depth=%0d",
                                     rsp_data.pick_hit, $signed(rsp_data.nearest_depth)));
            end else begin
               want = due_picks.pop_front();
               picks_checked++;
               if (want.pick_hit) picks_hit++;
               if (rsp_data.pick_hit !== want.pick_hit ||
                   rsp_data.nearest_depth !== want.nearest_depth) begin
                  log_failure($sformatf(
                     "pick result %0d: expected hit=%0d depth=%0d, got hit=%0d depth=%0d",
                     picks_checked, want.pick_hit, $signed(want.nearest_depth),
                     rsp_data.pick_hit, $signed(rsp_data.nearest_depth)));
               end
            end
         end
         if (req_moved) begin
            fold_triangle(req_data);
            triangles_seen++;
         end
      end
   end

   // Stimulus sequence.
   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Directed queries at the reset pick point, the origin.
      // Counterclockwise and clockwise hits.
      add_triangle(make_triangle(-10, -10, 10, -10, 0, 10, 100, 200, 300, 1));
      add_triangle(make_triangle(-10, -10, 0, 10, 10, -10, -300, -600, -900, 1));
      // Collinear through the point, and all vertices on the point.
      add_triangle(make_triangle(-5, -5, 0, 0, 5, 5, 1, 2, 3, 1));
      add_triangle(make_triangle(0, 0, 0, 0, 0, 0, 4, 5, 6, 1));
      // Point on a vertex, then on an edge.
      add_triangle(make_triangle(0, 0, 10, 0, 0, 10, 3, 3, 3, 1));
      add_triangle(make_triangle(-10, 0, 10, 0, 0, -10, 7, 8, 9, 1));
      // Clear miss.
      add_triangle(make_triangle(1, 1, 10, 1, 1, 10, 11, 12, 13, 1));
      // Nearer hit replaces, equal sum does not, miss closes the query.
      add_triangle(make_triangle(-10, -10, 10, -10, 0, 10, 300, 300, 300, 0));
      add_triangle(make_triangle(-10, -10, 10, -10, 0, 10, 50, 50, 50, 0));
      add_triangle(make_triangle(-10, -10, 0, 10, 10, -10, 100, 25, 25, 0));
      add_triangle(make_triangle(1, 1, 10, 1, 1, 10, -999, -999, -999, 1));
      // Depth extremes.
      add_triangle(make_triangle(-10, -10, 10, -10, 0, 10,
                                 DEPTH_MAX, DEPTH_MAX, DEPTH_MAX, 0));
      add_triangle(make_triangle(-10, -10, 10, -10, 0, 10,
                                 DEPTH_MIN, DEPTH_MIN, DEPTH_MIN, 1));
      add_triangle(make_triangle(-10, -10, 0, 10, 10, -10,
                                 DEPTH_MAX, DEPTH_MAX, DEPTH_MAX, 1));
      // Full-screen triangles in both windings; negative sums truncate toward zero.
      add_triangle(make_triangle(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN,
                                 0, COORD_MAX, -1, -1, 0, 1));
      add_triangle(make_triangle(COORD_MIN, COORD_MIN, 0, COORD_MAX,
                                 COORD_MAX, COORD_MIN, -2, -2, 0, 1));
      // Point on the long diagonal edge of a corner-to-corner triangle.
      add_triangle(make_triangle(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                                 COORD_MIN, COORD_MAX, 5, 5, 5, 1));
      // Hit in the middle of a query survives a closing miss.
      add_triangle(make_triangle(0, 0, 10, 0, 0, 10, 10, 10, 10, 0));
      add_triangle(make_triangle(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN,
                                 COORD_MAX - 1, 0, 0, 0, 0, 1));
      wait_idle();

      // Random phases over pick points at the corners and inside the screen.
      run_phase(37, -12, 0, 0, 120, 1'b0);
      run_phase(COORD_MIN, COORD_MAX, 51, 0, 110, 1'b0);
      run_phase(COORD_MAX, COORD_MIN, 0, 51, 110, 1'b0);
      run_phase(random_coord(), random_coord(), 30, 30, 120, 1'b0);
      run_phase(COORD_MIN, COORD_MIN, 30, 30, 90, 1'b0);
      run_phase(-5, 7, 0, 0, 80, 1'b1);
      run_phase(COORD_MAX, COORD_MAX, 0, 0, 40, 1'b0);

      $display("Covered %0d triangles in %0d pick queries, %0d of them hits.",
               triangles_seen, picks_checked, picks_hit);
      $display("Pick point at all four corners and inside; input stalled %0d cycles by hold-off.",
               input_held_cycles);
      if (failures == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   // Watchdog, far above the slowest correct run.
   initial begin
      #2_000_000;
      $display("testbench failed");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/stpn_pkg.sv
hw/rtl/stpn_front.sv
hw/rtl/stpn_queue.sv
hw/rtl/stpn_back.sv
hw/rtl/screen_triangle_pick_nearest.sv
dv/testbench.sv
